// ===== src/itrt_pkg.sv =====
// ----------------------------------------------------------------------------
// itrt_pkg
// Shared constants and helpers for the integer to radix text converter.
// ----------------------------------------------------------------------------
package itrt_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int RADIX_WIDTH = 6;
   localparam int CHAR_WIDTH  = 8;

   localparam logic [RADIX_WIDTH-1:0] RADIX_MIN   = 6'd2;
   localparam logic [RADIX_WIDTH-1:0] RADIX_MAX   = 6'd36;
   localparam logic [RADIX_WIDTH-1:0] RADIX_RESET = 6'd10;

   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ALPHA = 8'h41;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [RADIX_WIDTH-1:0] DECIMAL_DIGITS = 6'd10;

   typedef logic [RADIX_WIDTH-1:0] digit_type;
   typedef logic [CHAR_WIDTH-1:0]  char_type;

   // Map a digit value 0..35 to '0'-'9', 'A'-'Z'.
   function automatic char_type digit_char(input digit_type d);
      char_type c;
      if (d < DECIMAL_DIGITS) begin
         c = CHAR_ZERO + {2'b00, d};
      end else begin
         c = CHAR_ALPHA + {2'b00, d - DECIMAL_DIGITS};
      end
      return c;
   endfunction

   // Clamp a written base into 2..36.
   function automatic digit_type clamp_radix(input digit_type r);
      digit_type c;
      if (r < RADIX_MIN) begin
         c = RADIX_MIN;
      end else if (r > RADIX_MAX) begin
         c = RADIX_MAX;
      end else begin
         c = r;
      end
      return c;
   endfunction

endpackage

// ===== src/integer_to_radix_text.sv =====
// ----------------------------------------------------------------------------
// integer_to_radix_text
// Converts a signed integer into ASCII text in a configurable radix.
// ----------------------------------------------------------------------------
// Usage:
//   Pulse start with req_value while busy is low; the item is taken at that
//   edge and busy stays high until the last character has been launched.
//   Characters leave most significant first on rsp_text_char, each held for
//   one cycle with rsp_valid high; rsp_last_char marks the final one. A
//   negative value is preceded by '-'. The receiver has no back pressure.
//   The radix register is written over csr_valid/csr_ready (always ready) and
//   is clamped into 2..36; write it only while busy is low.
// Timing:
//   A bit-serial restoring divider produces one remainder digit per pass over
//   the magnitude and pushes it on a digit stack, least significant first;
//   then '-' for a negative value and the digits popped from the stack are
//   emitted, so the conversion time grows with the digit count.
//   A new item may be accepted in the cycle the last character is shown.
// Reset:
//   Synchronous reset returns to idle, drops rsp_valid and sets radix to 10.
// ----------------------------------------------------------------------------
module integer_to_radix_text
   import itrt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [VALUE_WIDTH-1:0] req_value,
   output logic                   rsp_valid,
   output logic [CHAR_WIDTH-1:0]  rsp_text_char,
   output logic                   rsp_last_char,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [RADIX_WIDTH-1:0] csr_wdata
);

   localparam int DEPTH = VALUE_WIDTH;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int SP_W  = $clog2(DEPTH + 1);
   localparam int CNT_W = $clog2(VALUE_WIDTH);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_WIDTH - 1);
   localparam logic [SP_W-1:0]  SP_ONE   = SP_W'(1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_SIGN = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [RADIX_WIDTH-1:0] radix_ff;
   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic [RADIX_WIDTH-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]       cnt_ff;
   logic [SP_W-1:0]        sp_ff;
   logic                   neg_ff;
   logic                   rsp_valid_ff;
   char_type               rsp_text_char_ff;
   logic                   rsp_last_char_ff;
   digit_type              stack [DEPTH];

   logic                   accept;
   logic [RADIX_WIDTH:0]   rem_shift;
   logic                   fits;
   logic [RADIX_WIDTH:0]   rem_diff;
   logic [VALUE_WIDTH-1:0] start_mag;
   logic [SP_W-1:0]        sp_dec;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   assign start_mag = req_value[VALUE_WIDTH-1] ? (~req_value + VALUE_WIDTH'(1)) : req_value;

   // One restoring division step: bring in the next dividend bit.
   always_comb begin
      rem_shift = {rem_ff, mag_ff[VALUE_WIDTH-1]};
      fits      = (rem_shift >= {1'b0, radix_ff});
      rem_diff  = rem_shift - {1'b0, radix_ff};
      rem_in    = fits ? rem_diff[RADIX_WIDTH-1:0] : rem_shift[RADIX_WIDTH-1:0];
      mag_in    = {mag_ff[VALUE_WIDTH-2:0], fits};
      sp_dec    = sp_ff - SP_ONE;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (cnt_ff == CNT_LAST && mag_in == '0) begin
               state_in = neg_ff ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: state_in = ST_EMIT;
         ST_EMIT: begin
            if (sp_ff == SP_ONE) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         radix_ff     <= RADIX_RESET;
         rsp_valid_ff <= 1'b0;
         sp_ff        <= '0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == ST_SIGN) || (state_ff == ST_EMIT);
         if (csr_valid && csr_ready) radix_ff <= clamp_radix(csr_wdata);
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  sp_ff  <= '0;
                  cnt_ff <= '0;
               end
            end
            ST_DIV: begin
               cnt_ff <= (cnt_ff == CNT_LAST) ? '0 : cnt_ff + CNT_W'(1);
               if (cnt_ff == CNT_LAST) sp_ff <= sp_ff + SP_ONE;
            end
            ST_EMIT: sp_ff <= sp_dec;
            default: ;
         endcase
      end
   end

   // Datapath: magnitude shift register, remainder, digit stack, output.
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && accept) begin
         mag_ff <= start_mag;
         neg_ff <= req_value[VALUE_WIDTH-1];
         rem_ff <= '0;
      end else if (state_ff == ST_DIV) begin
         mag_ff <= mag_in;
         if (cnt_ff == CNT_LAST) begin
            // Push the finished digit and restart the remainder.
            stack[sp_ff[IDX_W-1:0]] <= rem_in;
            rem_ff <= '0;
         end else begin
            rem_ff <= rem_in;
         end
      end
      if (state_ff == ST_SIGN) begin
         rsp_text_char_ff <= CHAR_MINUS;
         rsp_last_char_ff <= 1'b0;
      end else begin
         rsp_text_char_ff <= digit_char(stack[sp_dec[IDX_W-1:0]]);
         rsp_last_char_ff <= (sp_ff == SP_ONE);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_text_char = rsp_text_char_ff;
   assign rsp_last_char = rsp_last_char_ff;

endmodule
